[sv/prl_pkg.sv]
// Types and constants shared by the per-peer rate limiter.
package prl_pkg;

  localparam int unsigned ADDR_W  = 64;
  localparam int unsigned WHOLE_W = 32;
  localparam int unsigned FRAC_W  = 8;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned GRACE_W = 16;
  localparam int unsigned PEN_W   = 15;
  localparam int unsigned PROD_W  = PEN_W + CFG_W;
  localparam int unsigned SUM_W   = WHOLE_W + 1;

  localparam logic [CFG_W-1:0] SENSE_RST     = 16'd256;
  localparam logic [CFG_W-1:0] MAX_AHEAD_RST = 16'd60;

  localparam logic CFG_SENSE     = 1'b0;
  localparam logic CFG_MAX_AHEAD = 1'b1;

  localparam logic CMD_CHECK   = 1'b0;
  localparam logic CMD_PENALTY = 1'b1;

  typedef enum logic [1:0] {
    T_IDLE,
    T_SCAN,
    T_CALC,
    T_DONE
  } top_state_e;

  typedef enum logic [2:0] {
    C_IDLE,
    C_STEP1,
    C_STEP2,
    C_STEP3,
    C_STEP4
  } calc_state_e;

  typedef struct packed {
    logic               cmd;
    logic               is_v6;
    logic [ADDR_W-1:0]  addr_hi;
    logic [ADDR_W-1:0]  addr_lo;
    logic [WHOLE_W-1:0] now;
    logic [GRACE_W-1:0] grace;
    logic [PEN_W-1:0]   penalty;
  } prl_in_t;

  typedef struct packed {
    logic blocked;
    logic table_full;
  } prl_out_t;

  typedef struct packed {
    logic               is_v6;
    logic [ADDR_W-1:0]  key_hi;
    logic [ADDR_W-1:0]  key_lo;
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
  } prl_entry_t;

  typedef struct packed {
    logic               cmd;
    logic [WHOLE_W-1:0] now;
    logic [GRACE_W-1:0] grace;
    logic [PEN_W-1:0]   penalty;
    logic [CFG_W-1:0]   sense;
    logic [CFG_W-1:0]   max_ahead;
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
  } prl_calc_req_t;

  typedef struct packed {
    logic               blocked;
    logic [WHOLE_W-1:0] whole;
    logic [FRAC_W-1:0]  frac;
  } prl_calc_res_t;

endpackage

[sv/prl_if.sv]
// Valid/ready channel interfaces for the rate limiter's input and result beats.
interface prl_in_if
  import prl_pkg::*;
;
  logic    valid;
  logic    ready;
  prl_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface prl_out_if
  import prl_pkg::*;
;
  logic     valid;
  logic     ready;
  prl_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/prl_calc.sv]
// Stamp update sequencer built around one shared 33-bit adder.
module prl_calc
  import prl_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  prl_calc_req_t req_i,
  output logic          done_o,
  output prl_calc_res_t res_o
);

  calc_state_e        state_q, state_d;
  logic [SUM_W-1:0]   lim_q, lim_d;
  logic [SUM_W-1:0]   acc_q, acc_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [WHOLE_W-1:0] base_q, base_d;
  prl_calc_res_t      res_q, res_d;
  logic               done_q, done_d;

  logic [WHOLE_W-1:0] alu_a, alu_b;
  logic [SUM_W-1:0]   alu_sum;
  logic [SUM_W-1:0]   clamp;

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lim_q  <= lim_d;
    acc_q  <= acc_d;
    sum_q  <= sum_d;
    prod_q <= prod_d;
    base_q <= base_d;
    res_q  <= res_d;
  end

  always_comb begin
    state_d = state_q;
    lim_d   = lim_q;
    acc_d   = acc_q;
    sum_d   = sum_q;
    prod_d  = prod_q;
    base_d  = base_q;
    res_d   = res_q;
    done_d  = 1'b0;
    alu_a   = '0;
    alu_b   = '0;
    clamp   = '0;
    unique case (state_q)
      C_IDLE: begin
        if (start_i) state_d = C_STEP1;
      end
      C_STEP1: begin
        if (req_i.cmd == CMD_CHECK) begin
          alu_a = req_i.now;
          alu_b = {{(WHOLE_W-GRACE_W){1'b0}}, req_i.grace};
          lim_d = alu_sum;
        end else begin
          prod_d = {{CFG_W{1'b0}}, req_i.penalty} * {{PEN_W{1'b0}}, req_i.sense};
          base_d = (req_i.now > req_i.whole) ? req_i.now : req_i.whole;
        end
        state_d = C_STEP2;
      end
      C_STEP2: begin
        if (req_i.cmd == CMD_CHECK) begin
          alu_a = {{(WHOLE_W-FRAC_W){1'b0}}, req_i.frac};
          alu_b = {{(WHOLE_W-CFG_W){1'b0}}, req_i.sense};
        end else begin
          alu_a = {{(WHOLE_W-PROD_W){1'b0}}, prod_q};
          alu_b = {{(WHOLE_W-FRAC_W){1'b0}}, req_i.frac};
        end
        acc_d   = alu_sum;
        state_d = C_STEP3;
      end
      C_STEP3: begin
        if (req_i.cmd == CMD_CHECK) begin
          alu_a = req_i.whole;
          alu_b = {{(WHOLE_W-9){1'b0}}, acc_q[16:8]};
          res_d.blocked = ({1'b0, req_i.whole} > lim_q);
          if ({1'b0, req_i.whole} > lim_q) begin
            res_d.whole = req_i.whole;
            res_d.frac  = req_i.frac;
          end else if (req_i.now > req_i.whole) begin
            res_d.whole = req_i.now;
            res_d.frac  = '0;
          end else begin
            res_d.whole = alu_sum[WHOLE_W] ? '1 : alu_sum[WHOLE_W-1:0];
            res_d.frac  = acc_q[FRAC_W-1:0];
          end
          done_d  = 1'b1;
          state_d = C_IDLE;
        end else begin
          alu_a   = base_q;
          alu_b   = {{FRAC_W{1'b0}}, acc_q[WHOLE_W-1:FRAC_W]};
          sum_d   = alu_sum;
          state_d = C_STEP4;
        end
      end
      C_STEP4: begin
        alu_a = req_i.now;
        alu_b = {{(WHOLE_W-CFG_W){1'b0}}, req_i.max_ahead};
        clamp = (sum_q > alu_sum) ? alu_sum : sum_q;
        res_d.blocked = 1'b0;
        res_d.whole   = clamp[WHOLE_W] ? '1 : clamp[WHOLE_W-1:0];
        res_d.frac    = acc_q[FRAC_W-1:0];
        done_d  = 1'b1;
        state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[sv/per_peer_abuse_rate_limiter.sv]
// Per-peer rate limiter: each beat on in_if is a check or a penalty for one
// peer address and yields exactly one beat on out_if (blocked, table_full).
// Configuration: cfg_we_i writes cfg_wdata_i to sense (index 0) or max_ahead
// (index 1); write only while the block is idle.
// One item is in flight at a time; in_if.ready is high only while idle.
// A zero penalty goes straight to the result without touching the table.
// Otherwise the peer table is scanned one entry per cycle through a single
// memory read port, then the stamp is updated by a shared-adder sequencer
// (3 steps for a check, 4 for a penalty) and written back. in_if.ready
// rises together with the result beat.
// Results sit in an output register; the next item is accepted while a
// result waits. If the receiver stalls and a second result is ready, the
// block holds it and takes no new item until the register frees.
// Reset empties the table (all valid bits clear at once), restores sense to
// 256 and max_ahead to 60, and drops any pending result.
module per_peer_abuse_rate_limiter
  import prl_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  prl_in_if.sink           in_if,
  prl_out_if.source        out_if,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNTW = $clog2(ENTRIES + 1);

  top_state_e state_q, state_d;

  logic [CFG_W-1:0]   sense_q, max_ahead_q;

  logic               cmd_q, cmd_d;
  logic               v6_q, v6_d;
  logic [ADDR_W-1:0]  hi_q, hi_d;
  logic [ADDR_W-1:0]  lo_q, lo_d;
  logic [WHOLE_W-1:0] now_q, now_d;
  logic [GRACE_W-1:0] grace_q, grace_d;
  logic [PEN_W-1:0]   pen_q, pen_d;

  logic [ENTRIES-1:0] valid_q;
  prl_entry_t         tbl_mem [ENTRIES];
  prl_entry_t         rd_q;
  prl_entry_t         wr_entry;
  logic               mem_re, mem_we;

  logic [CNTW-1:0]    iss_q, iss_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IDXW-1:0]    cmp_idx_q, cmp_idx_d;
  logic               free_vld_q, free_vld_d;
  logic [IDXW-1:0]    free_idx_q, free_idx_d;
  logic [IDXW-1:0]    slot_q, slot_d;
  logic [WHOLE_W-1:0] whole_q, whole_d;
  logic [FRAC_W-1:0]  frac_q, frac_d;
  logic               wr_q, wr_d;
  logic               blk_q, blk_d;
  logic               full_q, full_d;
  logic               start_q, start_d;

  logic               out_vld_q, out_vld_d;
  prl_out_t           out_data_q, out_data_d;

  logic               hit, is_free, last;
  logic               calc_done;
  prl_calc_req_t      calc_req;
  prl_calc_res_t      calc_res;

  assign in_if.ready = (state_q == T_IDLE);
  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_data_q;

  assign hit = cmp_vld_q && valid_q[cmp_idx_q] && (rd_q.is_v6 == v6_q) &&
               (rd_q.key_hi == hi_q) && (rd_q.key_lo == lo_q);
  assign is_free = cmp_vld_q && !valid_q[cmp_idx_q];
  assign last    = cmp_vld_q && (cmp_idx_q == IDXW'(ENTRIES - 1));

  assign mem_re = (state_q == T_SCAN) && (iss_q < CNTW'(ENTRIES));
  assign mem_we = (state_q == T_DONE) && (!out_vld_q || out_if.ready) && wr_q;

  assign wr_entry = '{is_v6: v6_q, key_hi: hi_q, key_lo: lo_q,
                      whole: whole_q, frac: frac_q};

  assign calc_req = '{cmd: cmd_q, now: now_q, grace: grace_q, penalty: pen_q,
                      sense: sense_q, max_ahead: max_ahead_q,
                      whole: whole_q, frac: frac_q};

  prl_calc u_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .req_i   (calc_req),
    .done_o  (calc_done),
    .res_o   (calc_res)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) tbl_mem[slot_q] <= wr_entry;
    if (mem_re) rd_q <= tbl_mem[iss_q[IDXW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sense_q     <= SENSE_RST;
      max_ahead_q <= MAX_AHEAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SENSE:     sense_q     <= cfg_wdata_i;
        CFG_MAX_AHEAD: max_ahead_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= T_IDLE;
      valid_q    <= '0;
      out_vld_q  <= 1'b0;
      start_q    <= 1'b0;
      cmp_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
      wr_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      out_vld_q  <= out_vld_d;
      start_q    <= start_d;
      cmp_vld_q  <= cmp_vld_d;
      free_vld_q <= free_vld_d;
      wr_q       <= wr_d;
      if (mem_we) valid_q[slot_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    v6_q       <= v6_d;
    hi_q       <= hi_d;
    lo_q       <= lo_d;
    now_q      <= now_d;
    grace_q    <= grace_d;
    pen_q      <= pen_d;
    iss_q      <= iss_d;
    cmp_idx_q  <= cmp_idx_d;
    free_idx_q <= free_idx_d;
    slot_q     <= slot_d;
    whole_q    <= whole_d;
    frac_q     <= frac_d;
    blk_q      <= blk_d;
    full_q     <= full_d;
    out_data_q <= out_data_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    v6_d       = v6_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    now_d      = now_q;
    grace_d    = grace_q;
    pen_d      = pen_q;
    iss_d      = iss_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = cmp_idx_q;
    free_vld_d = free_vld_q;
    free_idx_d = free_idx_q;
    slot_d     = slot_q;
    whole_d    = whole_q;
    frac_d     = frac_q;
    wr_d       = wr_q;
    blk_d      = blk_q;
    full_d     = full_q;
    start_d    = 1'b0;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;

    if (out_vld_q && out_if.ready) out_vld_d = 1'b0;

    unique case (state_q)
      T_IDLE: begin
        if (in_if.valid) begin
          cmd_d   = in_if.data.cmd;
          v6_d    = in_if.data.is_v6;
          hi_d    = in_if.data.is_v6 ? in_if.data.addr_hi : '0;
          lo_d    = in_if.data.is_v6 ? in_if.data.addr_lo
                                     : {32'b0, in_if.data.addr_lo[31:0]};
          now_d   = in_if.data.now;
          grace_d = in_if.data.grace;
          pen_d   = in_if.data.penalty;
          blk_d   = 1'b0;
          full_d  = 1'b0;
          wr_d    = 1'b0;
          iss_d   = '0;
          free_vld_d = 1'b0;
          if (in_if.data.cmd == CMD_PENALTY && in_if.data.penalty == '0) begin
            state_d = T_DONE;
          end else begin
            state_d = T_SCAN;
          end
        end
      end
      T_SCAN: begin
        if (mem_re) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = iss_q[IDXW-1:0];
          iss_d     = iss_q + CNTW'(1);
        end
        if (hit) begin
          slot_d    = cmp_idx_q;
          whole_d   = rd_q.whole;
          frac_d    = rd_q.frac;
          wr_d      = 1'b1;
          start_d   = 1'b1;
          cmp_vld_d = 1'b0;
          state_d   = T_CALC;
        end else begin
          if (is_free && !free_vld_q) begin
            free_vld_d = 1'b1;
            free_idx_d = cmp_idx_q;
          end
          if (last) begin
            if (free_vld_q || is_free) begin
              slot_d  = free_vld_q ? free_idx_q : cmp_idx_q;
              whole_d = '0;
              frac_d  = '0;
              wr_d    = 1'b1;
              start_d = 1'b1;
              state_d = T_CALC;
            end else begin
              full_d  = 1'b1;
              wr_d    = 1'b0;
              state_d = T_DONE;
            end
          end
        end
      end
      T_CALC: begin
        if (calc_done) begin
          blk_d   = calc_res.blocked;
          whole_d = calc_res.whole;
          frac_d  = calc_res.frac;
          state_d = T_DONE;
        end
      end
      T_DONE: begin
        if (!out_vld_q || out_if.ready) begin
          out_vld_d  = 1'b1;
          out_data_d = '{blocked: blk_q, table_full: full_q};
          wr_d       = 1'b0;
          state_d    = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

endmodule

[sv/prl_checker.sv]
// Port-level checks for the rate limiter, bound to the top level.
module prl_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_blocked_i,
  input logic out_full_i
);

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while an item is still in flight");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_i)
    else $error("result beat shown during reset");

  a_full_not_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(out_blocked_i && out_full_i))
    else $error("full table result also reports blocked");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      out_valid_i && $stable(out_blocked_i) && $stable(out_full_i))
    else $error("stalled result beat changed");

endmodule

bind per_peer_abuse_rate_limiter prl_checker u_prl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .out_blocked_i (out_if.data.blocked),
  .out_full_i    (out_if.data.table_full)
);
